[hw/rtl/mnkm_pkg.sv]
// Shared types, codes and character classes for the math notation keystroke matcher.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package mnkm_pkg;

    typedef logic [1:0] op_t;

    localparam op_t OP_ADD    = 2'd0;
    localparam op_t OP_REMOVE = 2'd1;
    localparam op_t OP_CLEAR  = 2'd2;
    localparam op_t OP_NONE   = 2'd3;

    localparam logic [1:0] ACTION_ADD    = 2'd0;
    localparam logic [1:0] ACTION_REMOVE = 2'd1;
    localparam logic [1:0] ACTION_RESET  = 2'd2;

    localparam logic [3:0] KIND_NONE      = 4'd0;
    localparam logic [3:0] KIND_WORD      = 4'd1;
    localparam logic [3:0] KIND_SUP_PAIR  = 4'd2;
    localparam logic [3:0] KIND_SUB_PAIR  = 4'd3;
    localparam logic [3:0] KIND_SUP_OPEN  = 4'd4;
    localparam logic [3:0] KIND_SUB_OPEN  = 4'd5;
    localparam logic [3:0] KIND_SUP_CLOSE = 4'd6;
    localparam logic [3:0] KIND_SUB_CLOSE = 4'd7;
    localparam logic [3:0] KIND_SUP_CHAR  = 4'd8;
    localparam logic [3:0] KIND_SUB_CHAR  = 4'd9;

    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;

    localparam int MAX_RESULTS   = 32;
    localparam int MIN_WORD_SPAN = 4;
    localparam int QUEUE_DEPTH   = 2;

    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
        logic       pair;
        logic       open_paren;
        logic       close_paren;
        logic       space;
    } cmd_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_pair_char(input logic [7:0] c);
        return is_letter(c) || (c >= 8'h30 && c <= 8'h39) || c == CH_PLUS ||
               c == CH_MINUS || c == CH_EQUAL || c == CH_LPAREN ||
               c == CH_RPAREN || c == CH_SLASH;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/mnkm_front.sv]
// Front end: takes keystroke beats, decodes the action and classifies the character.
// Depends on mnkm_pkg; pushes classified commands into mnkm_queue.
`default_nettype none

module mnkm_front
(
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [1:0]    action,
    input  wire logic [7:0]    typed_char,
    input  wire logic          queue_full,
    output logic               push,
    output mnkm_pkg::cmd_t     cmd
);

    always_comb
    begin
        in_stall = queue_full;
        push     = in_valid && !queue_full;
        case (action)
            mnkm_pkg::ACTION_ADD:    cmd.op = mnkm_pkg::OP_ADD;
            mnkm_pkg::ACTION_REMOVE: cmd.op = mnkm_pkg::OP_REMOVE;
            mnkm_pkg::ACTION_RESET:  cmd.op = mnkm_pkg::OP_CLEAR;
            default:                 cmd.op = mnkm_pkg::OP_NONE;
        endcase
        cmd.ch          = typed_char;
        cmd.pair        = mnkm_pkg::is_pair_char(typed_char);
        cmd.open_paren  = (typed_char == mnkm_pkg::CH_LPAREN);
        cmd.close_paren = (typed_char == mnkm_pkg::CH_RPAREN);
        cmd.space       = (typed_char == mnkm_pkg::CH_SPACE);
    end

endmodule

`default_nettype wire

[hw/rtl/mnkm_queue.sv]
// Short command queue between the front end and the matching engine.
// Depends on mnkm_pkg for the command type and the queue depth.
`default_nettype none

module mnkm_queue
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire mnkm_pkg::cmd_t  cmd_in,
    output logic                 full,
    input  wire logic            pop,
    output logic                 cmd_valid,
    output mnkm_pkg::cmd_t       cmd_out
);

    localparam int PW = (mnkm_pkg::QUEUE_DEPTH > 1) ? $clog2(mnkm_pkg::QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(mnkm_pkg::QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(mnkm_pkg::QUEUE_DEPTH - 1);

    mnkm_pkg::cmd_t slot_reg [mnkm_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [NW-1:0]  count_reg;
    logic [NW-1:0]  count_next;

    always_comb
    begin
        full      = (count_reg == NW'(mnkm_pkg::QUEUE_DEPTH));
        cmd_valid = (count_reg != '0);
        cmd_out   = slot_reg[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/mnkm_back.sv]
// Matching engine: character window memory, mode flags, match sequencer and result register.
// Depends on mnkm_pkg; takes commands from mnkm_queue.
`default_nettype none

module mnkm_back
#(
    parameter int BUFFER_DEPTH = 32
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    input  wire mnkm_pkg::cmd_t cmd,
    output logic               cmd_pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [3:0]         match_kind,
    output logic [4:0]         match_pos,
    output logic [5:0]         match_length,
    output logic [7:0]         pattern_char,
    output logic               last_of_run
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam logic [CW:0]   DEPTH_W  = (CW + 1)'(BUFFER_DEPTH);
    localparam logic [CW-1:0] DEPTH_C  = CW'(BUFFER_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(BUFFER_DEPTH - 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CHECK    = 3'd1;
    localparam logic [2:0] S_SCAN_RD  = 3'd2;
    localparam logic [2:0] S_SCAN_CHK = 3'd3;
    localparam logic [2:0] S_EMIT_RD  = 3'd4;
    localparam logic [2:0] S_EMIT_WR  = 3'd5;
    localparam logic [2:0] S_NONE     = 3'd6;

    logic [7:0] mem [BUFFER_DEPTH];

    logic [2:0]      state_reg, state_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic [AW-1:0]   head_reg, head_next;
    logic            sup_reg, sup_next;
    logic            sub_reg, sub_next;
    mnkm_pkg::cmd_t  cur_reg, cur_next;
    logic [CW-1:0]   scan_reg, scan_next;
    logic [CW-1:0]   bs_reg, bs_next;
    logic [4:0]      k_reg, k_next;
    logic [4:0]      wlast_reg, wlast_next;
    logic [7:0]      rdata_reg;

    logic            out_valid_reg, out_valid_next;
    logic [3:0]      kind_reg, kind_next;
    logic [4:0]      pos_reg, pos_next;
    logic [5:0]      len_reg, len_next;
    logic [7:0]      char_reg, char_next;
    logic            last_reg, last_next;

    logic            mem_we;
    logic [AW-1:0]   wr_addr;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            out_free;
    logic            out_load;
    logic            has_prev;
    logic [CW-1:0]   span;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [CW-1:0] idx);
        logic [CW:0] sum;
        sum = (CW + 1)'(base) + (CW + 1)'(idx);
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    assign out_valid    = out_valid_reg;
    assign match_kind   = kind_reg;
    assign match_pos    = pos_reg;
    assign match_length = len_reg;
    assign pattern_char = char_reg;
    assign last_of_run  = last_reg;

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        head_next  = head_reg;
        sup_next   = sup_reg;
        sub_next   = sub_reg;
        cur_next   = cur_reg;
        scan_next  = scan_reg;
        bs_next    = bs_reg;
        k_next     = k_reg;
        wlast_next = wlast_reg;
        cmd_pop    = 1'b0;
        mem_we     = 1'b0;
        wr_addr    = '0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        out_free   = !out_valid_reg || !out_stall;
        out_load   = 1'b0;
        kind_next  = mnkm_pkg::KIND_NONE;
        pos_next   = '0;
        len_next   = '0;
        char_next  = '0;
        last_next  = 1'b1;
        has_prev   = (fill_reg >= CW'(2));
        span       = fill_reg - scan_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    cur_next = cmd;
                    case (cmd.op)
                        mnkm_pkg::OP_ADD:
                        begin
                            mem_we = 1'b1;
                            if (fill_reg == DEPTH_C)
                            begin
                                wr_addr   = head_reg;
                                head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                            end
                            else
                            begin
                                wr_addr   = phys(head_reg, fill_reg);
                                fill_next = fill_reg + 1'b1;
                            end
                            if (fill_next >= CW'(2))
                            begin
                                rd_en   = 1'b1;
                                rd_addr = phys(head_next, fill_next - CW'(2));
                            end
                            state_next = S_CHECK;
                        end
                        mnkm_pkg::OP_REMOVE:
                        begin
                            if (fill_reg != '0)
                            begin
                                fill_next = fill_reg - 1'b1;
                            end
                            state_next = S_NONE;
                        end
                        mnkm_pkg::OP_CLEAR:
                        begin
                            fill_next  = '0;
                            head_next  = '0;
                            sup_next   = 1'b0;
                            sub_next   = 1'b0;
                            state_next = S_NONE;
                        end
                        default:
                        begin
                            state_next = S_NONE;
                        end
                    endcase
                end
            end

            S_CHECK:
            begin
                if (cur_reg.open_paren && has_prev && rdata_reg == mnkm_pkg::CH_CARET)
                begin
                    kind_next = mnkm_pkg::KIND_SUP_OPEN;
                    pos_next  = 5'(fill_reg - CW'(2));
                    len_next  = 6'd2;
                    char_next = mnkm_pkg::CH_LPAREN;
                    if (out_free)
                    begin
                        sup_next = 1'b1;
                    end
                end
                else if (cur_reg.open_paren && has_prev && rdata_reg == mnkm_pkg::CH_UNDER)
                begin
                    kind_next = mnkm_pkg::KIND_SUB_OPEN;
                    pos_next  = 5'(fill_reg - CW'(2));
                    len_next  = 6'd2;
                    char_next = mnkm_pkg::CH_LPAREN;
                    if (out_free)
                    begin
                        sub_next = 1'b1;
                    end
                end
                else if (cur_reg.close_paren && (sup_reg || sub_reg))
                begin
                    kind_next = sup_reg ? mnkm_pkg::KIND_SUP_CLOSE : mnkm_pkg::KIND_SUB_CLOSE;
                    pos_next  = 5'(fill_reg - CW'(1));
                    len_next  = 6'd1;
                    char_next = mnkm_pkg::CH_RPAREN;
                    if (out_free)
                    begin
                        sup_next = 1'b0;
                        sub_next = 1'b0;
                    end
                end
                else if (sup_reg || sub_reg)
                begin
                    kind_next = sup_reg ? mnkm_pkg::KIND_SUP_CHAR : mnkm_pkg::KIND_SUB_CHAR;
                    pos_next  = 5'(fill_reg - CW'(1));
                    len_next  = 6'd1;
                    char_next = cur_reg.ch;
                end
                else if (cur_reg.pair && has_prev && rdata_reg == mnkm_pkg::CH_CARET)
                begin
                    kind_next = mnkm_pkg::KIND_SUP_PAIR;
                    pos_next  = 5'(fill_reg - CW'(2));
                    len_next  = 6'd2;
                    char_next = cur_reg.ch;
                end
                else if (cur_reg.pair && has_prev && rdata_reg == mnkm_pkg::CH_UNDER)
                begin
                    kind_next = mnkm_pkg::KIND_SUB_PAIR;
                    pos_next  = 5'(fill_reg - CW'(2));
                    len_next  = 6'd2;
                    char_next = cur_reg.ch;
                end

                if (cur_reg.space && !sup_reg && !sub_reg &&
                    fill_reg >= CW'(mnkm_pkg::MIN_WORD_SPAN))
                begin
                    scan_next  = fill_reg - CW'(2);
                    state_next = S_SCAN_RD;
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_SCAN_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = phys(head_reg, scan_reg);
                state_next = S_SCAN_CHK;
            end

            S_SCAN_CHK:
            begin
                if (rdata_reg == mnkm_pkg::CH_BSLASH)
                begin
                    if (span >= CW'(mnkm_pkg::MIN_WORD_SPAN))
                    begin
                        bs_next = scan_reg;
                        k_next  = '0;
                        if (int'(span) - 1 > mnkm_pkg::MAX_RESULTS)
                        begin
                            wlast_next = 5'(mnkm_pkg::MAX_RESULTS - 1);
                        end
                        else
                        begin
                            wlast_next = 5'(span - CW'(2));
                        end
                        state_next = S_EMIT_RD;
                    end
                    else
                    begin
                        state_next = S_NONE;
                    end
                end
                else if (!mnkm_pkg::is_letter(rdata_reg) || scan_reg == '0)
                begin
                    state_next = S_NONE;
                end
                else
                begin
                    scan_next  = scan_reg - 1'b1;
                    state_next = S_SCAN_RD;
                end
            end

            S_EMIT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = phys(head_reg, bs_reg + CW'(k_reg));
                state_next = S_EMIT_WR;
            end

            S_EMIT_WR:
            begin
                kind_next = mnkm_pkg::KIND_WORD;
                pos_next  = 5'(bs_reg);
                len_next  = 6'(fill_reg - bs_reg);
                char_next = rdata_reg;
                last_next = (k_reg == wlast_reg);
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (k_reg == wlast_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_EMIT_RD;
                    end
                end
            end

            S_NONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            head_reg      <= '0;
            sup_reg       <= 1'b0;
            sub_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            head_reg      <= head_next;
            sup_reg       <= sup_next;
            sub_reg       <= sub_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        scan_reg  <= scan_next;
        bs_reg    <= bs_next;
        k_reg     <= k_next;
        wlast_reg <= wlast_next;
        if (out_load)
        begin
            kind_reg <= kind_next;
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            char_reg <= char_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= cur_next.ch;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/math_notation_keystroke_matcher_unit.sv]
// Top level of the math notation keystroke matcher: front end, command queue, matching engine.
// Depends on mnkm_pkg, mnkm_front, mnkm_queue and mnkm_back.
`default_nettype none

// Each keystroke beat adds a character, removes the last one, resets the window and the
// superscript and subscript modes, or (action code 3) does nothing, and yields one or more
// result beats; last_of_run marks the final result of a keystroke. A two-entry command queue
// lets keystrokes be taken while the engine is busy. A space that may end a backslash word
// makes the engine scan the window backward, one entry per step, to the backslash, and then
// emit one result per character of the word, backslash included; output stalls can hold each
// emitted result. The window memory has a registered read, so each scan or emit step reads
// in one state and uses the data in the state after it. The window is a circular buffer, so
// dropping the oldest character costs nothing, and no clearing pass is needed after reset.
module math_notation_keystroke_matcher_unit
#(
    parameter int BUFFER_DEPTH = 32
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [1:0]    action,
    input  wire logic [7:0]    typed_char,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [3:0]         match_kind,
    output logic [4:0]         match_pos,
    output logic [5:0]         match_length,
    output logic [7:0]         pattern_char,
    output logic               last_of_run
);

    mnkm_pkg::cmd_t push_cmd;
    mnkm_pkg::cmd_t head_cmd;
    logic           push;
    logic           queue_full;
    logic           head_valid;
    logic           pop;

    mnkm_front u_front
    (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .typed_char (typed_char),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    mnkm_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .cmd_in    (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .cmd_valid (head_valid),
        .cmd_out   (head_cmd)
    );

    mnkm_back
    #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (head_valid),
        .cmd          (head_cmd),
        .cmd_pop      (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .match_kind   (match_kind),
        .match_pos    (match_pos),
        .match_length (match_length),
        .pattern_char (pattern_char),
        .last_of_run  (last_of_run)
    );

endmodule

`default_nettype wire
